// File: rtl/rilbp_pkg.sv
`default_nettype none

package rilbp_pkg;

	// fixed field and register widths
	localparam int PIX_IN_BITS  = 8;
	localparam int CODE_BITS    = 8;
	localparam int WIDTH_BITS   = 11;
	localparam int HEIGHT_BITS  = 13;
	localparam int ROW_BITS     = 12;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	// parameter defaults
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// register limits and reset values
	localparam int MIN_DIM       = 3;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// result queue depth
	localparam int RES_DEPTH = 8;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 row_last;
		logic                 frame_last;
	} result_t;

	// smallest of the eight circular rotations of a comparison byte
	function automatic logic [CODE_BITS-1:0] min_rotation(input logic [CODE_BITS-1:0] code);
		logic [CODE_BITS-1:0] best;
		logic [CODE_BITS-1:0] rot;
		best = code;
		rot  = code;
		for (int k = 0; k < CODE_BITS - 1; k++) begin
			rot = {rot[CODE_BITS-2:0], rot[CODE_BITS-1]};
			if (rot < best) begin
				best = rot;
			end
		end
		return best;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rilbp_ram.sv
`default_nettype none

module rilbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first: a read and a write to one address return the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/rotation_invariant_lbp.sv
// Path: an accepted pixel passes stage 1 (window shift), stage 2 (ring compare) and stage 3
// (raw byte) before its pattern enters the result queue and m_tvalid rises.
// Throughput: one pixel per clock; input is held off only when the eight-entry result queue
// together with the three pipeline stages ahead of it could overflow.
// Reset (arst_n low, asynchronous): counters and window to zero, width 640, height 480,
// result queue empty; the line store is not cleared and needs no clearing pass.
`default_nettype none

module rotation_invariant_lbp #(
	parameter int MAX_WIDTH  = rilbp_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration port
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [rilbp_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [rilbp_pkg::APB_DATA_BITS-1:0]  pwdata,
	output      logic [rilbp_pkg::APB_DATA_BITS-1:0]  prdata,
	output      logic                                 pready,
	// pixel stream in
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	input  wire logic [rilbp_pkg::PIX_IN_BITS-1:0]    s_tdata,   // [7:0] pixel
	// pattern stream out
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	output      logic [rilbp_pkg::CODE_BITS-1:0]      m_tdata,   // [7:0] pattern_code
	output      logic                                 m_tlast,   // row_last
	output      logic                                 m_tuser    // [0] frame_last
);

	import rilbp_pkg::*;

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int CMPW    = ((CW > WIDTH_BITS) ? CW : WIDTH_BITS) + 1;
	localparam int WCAP    = (MAX_WIDTH > (2**WIDTH_BITS - 1)) ? (2**WIDTH_BITS - 1) : MAX_WIDTH;
	localparam int WRST    = (WIDTH_RESET > WCAP) ? WCAP : WIDTH_RESET;
	localparam int PTRW    = $clog2(RES_DEPTH);
	localparam int CNTW    = $clog2(RES_DEPTH + 1);
	localparam int CREDW   = $clog2(RES_DEPTH + 4);

	localparam logic [WIDTH_BITS-1:0]  WIDTH_CAP   = WIDTH_BITS'(WCAP);
	localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN   = WIDTH_BITS'(MIN_DIM);
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_CAP  = HEIGHT_BITS'(HEIGHT_LIMIT);
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN  = HEIGHT_BITS'(MIN_DIM);

	// ------------------------------------------------------------------
	// Configuration registers. Values are clamped on write and read back
	// as clamped. Any write restarts the frame.
	// ------------------------------------------------------------------
	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic                   cfg_wr;
	logic [WIDTH_BITS-1:0]  wr_width;
	logic [HEIGHT_BITS-1:0] wr_height;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		wr_width  = pwdata[WIDTH_BITS-1:0];
		wr_height = pwdata[HEIGHT_BITS-1:0];
		if (wr_width < WIDTH_MIN) begin
			wr_width = WIDTH_MIN;
		end else if (wr_width > WIDTH_CAP) begin
			wr_width = WIDTH_CAP;
		end
		if (wr_height < HEIGHT_MIN) begin
			wr_height = HEIGHT_MIN;
		end else if (wr_height > HEIGHT_CAP) begin
			wr_height = HEIGHT_CAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_BITS'(WRST);
			height_q <= HEIGHT_BITS'(HEIGHT_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= wr_width;
				REG_HEIGHT: height_q <= wr_height;
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = APB_DATA_BITS'(width_q);
			REG_HEIGHT: prdata = APB_DATA_BITS'(height_q);
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input side: raster counters and line store access.
	// Bank row_q[0] holds the row two above the current one: read it as
	// the top sample and overwrite it with the incoming pixel. The other
	// bank holds the row just above. Both reads are read-first, and the
	// same column comes round again only a whole row later, so no
	// forwarding is needed.
	// ------------------------------------------------------------------
	logic                  accept;
	logic [PIXEL_BITS-1:0] pix_in;
	logic [CW-1:0]         col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [CMPW-1:0]       col_inc;
	logic [HEIGHT_BITS-1:0] row_inc;
	logic                  col_wrap;
	logic                  row_wrap;
	logic                  emit;

	assign accept   = s_tvalid && s_tready;
	assign pix_in   = PIXEL_BITS'(s_tdata);
	assign col_inc  = CMPW'(col_q) + CMPW'(1);
	assign row_inc  = HEIGHT_BITS'(row_q) + HEIGHT_BITS'(1);
	assign col_wrap = col_inc >= CMPW'(width_q);
	assign row_wrap = row_inc >= height_q;
	assign emit     = (row_q >= ROW_BITS'(2)) && (col_q >= CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_BITS-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	logic [PIXEL_BITS-1:0] bank0_rd;
	logic [PIXEL_BITS-1:0] bank1_rd;

	rilbp_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_bank0 (
		.clk   (clk),
		.we    (accept && !row_q[0]),
		.waddr (col_q),
		.wdata (pix_in),
		.re    (accept),
		.raddr (col_q),
		.rdata (bank0_rd)
	);

	rilbp_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_bank1 (
		.clk   (clk),
		.we    (accept && row_q[0]),
		.waddr (col_q),
		.wdata (pix_in),
		.re    (accept),
		.raddr (col_q),
		.rdata (bank1_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1: line store data arrives; shift the window.
	// ------------------------------------------------------------------
	logic                  valid_s1;
	logic                  emit_s1;
	logic                  rl_s1;
	logic                  fl_s1;
	logic                  par_s1;
	logic [PIXEL_BITS-1:0] px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			rl_s1   <= col_wrap;
			fl_s1   <= col_wrap && (row_inc == height_q);
			par_s1  <= row_q[0];
			px_s1   <= pix_in;
		end
	end

	logic [PIXEL_BITS-1:0] top_s1;
	logic [PIXEL_BITS-1:0] mid_s1;
	logic [PIXEL_BITS-1:0] win_q [3][3];

	assign top_s1 = par_s1 ? bank1_rd : bank0_rd;
	assign mid_s1 = par_s1 ? bank0_rd : bank1_rd;

	// window row 0 is the oldest line, column 2 the newest pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= top_s1;
			win_q[1][2] <= mid_s1;
			win_q[2][2] <= px_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: compare the ring with the centre, clockwise from the upper
	// left, first neighbour in the top bit.
	// ------------------------------------------------------------------
	logic                  valid_s2;
	logic                  rl_s2;
	logic                  fl_s2;
	logic [CODE_BITS-1:0]  ring_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rl_s2 <= rl_s1;
			fl_s2 <= fl_s1;
		end
	end

	always_comb begin
		ring_code[7] = win_q[0][0] >= win_q[1][1];
		ring_code[6] = win_q[0][1] >= win_q[1][1];
		ring_code[5] = win_q[0][2] >= win_q[1][1];
		ring_code[4] = win_q[1][2] >= win_q[1][1];
		ring_code[3] = win_q[2][2] >= win_q[1][1];
		ring_code[2] = win_q[2][1] >= win_q[1][1];
		ring_code[1] = win_q[2][0] >= win_q[1][1];
		ring_code[0] = win_q[1][0] >= win_q[1][1];
	end

	// ------------------------------------------------------------------
	// Stage 3: hold the raw byte, then reduce to its minimum rotation on
	// the way into the result queue.
	// ------------------------------------------------------------------
	logic                 valid_s3;
	result_t              raw_s3;
	result_t              res_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			raw_s3.code       <= ring_code;
			raw_s3.row_last   <= rl_s2;
			raw_s3.frame_last <= fl_s2;
		end
	end

	always_comb begin
		res_in            = raw_s3;
		res_in.code       = min_rotation(raw_s3.code);
	end

	// ------------------------------------------------------------------
	// Result queue. The pipeline never stalls; instead input is refused
	// unless the queue has room for everything already in flight. The
	// credit check uses registers only, so no path runs from m_tready to
	// s_tready.
	// ------------------------------------------------------------------
	result_t          res_q [RES_DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             push;
	logic             pop;
	logic [CREDW-1:0] in_flight;

	assign push      = valid_s3;
	assign pop       = m_tvalid && m_tready;
	assign in_flight = CREDW'(cnt_q) + CREDW'(valid_s1) + CREDW'(valid_s2) + CREDW'(valid_s3);
	assign s_tready  = in_flight < CREDW'(RES_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = res_q[rd_ptr_q].code;
	assign m_tlast  = res_q[rd_ptr_q].row_last;
	assign m_tuser  = res_q[rd_ptr_q].frame_last;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= CREDW'(RES_DEPTH))
		else $error("result queue could overflow");

	a_frame_implies_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without row end");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(col_q) < CMPW'(width_q))
		else $error("column counter beyond row width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		HEIGHT_BITS'(row_q) < height_q)
		else $error("row counter beyond frame height");

endmodule

`default_nettype wire

// File: tb/sv/rotation_invariant_lbp_tb.sv
`default_nettype none

module rotation_invariant_lbp_tb;
	import rilbp_pkg::*;

	// time to let pass once the last expected pattern is out, as a margin for
	// pixels still in flight in the three pipeline stages that make no
	// pattern
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 16;
	// no transaction on any port for this long means the block has hung
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_CHUNK   = 40;

	typedef enum int {PIX_UNIFORM, PIX_FLAT, PIX_BINARY} pixel_style_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     psel     = 1'b0;
	logic                     penable  = 1'b0;
	logic                     pwrite   = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr    = '0;
	logic [APB_DATA_BITS-1:0] pwdata   = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [PIX_IN_BITS-1:0]   s_tdata  = '0;   // [7:0] pixel
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [CODE_BITS-1:0]     m_tdata;         // [7:0] pattern_code
	logic                     m_tlast;         // row_last
	logic                     m_tuser;         // [0] frame_last

	// shadow of the block: line store, window, raster position and frame size
	logic [PIX_IN_BITS-1:0] line_mem [0:2*MAX_WIDTH_DEF-1];
	logic [PIX_IN_BITS-1:0] win [0:2][0:2];
	int unsigned            col_pos;
	int unsigned            row_pos;
	int unsigned            frame_width;
	int unsigned            frame_height;

	// patterns predicted for accepted pixels, oldest first
	result_t expected_patterns [$];

	int src_gap_pct;
	int sink_stall_pct;
	int errors           = 0;
	int pixels_sent      = 0;
	int patterns_checked = 0;
	int reg_writes       = 0;
	int quiet_cycles     = 0;

	rotation_invariant_lbp dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Smallest value among the eight circular rotations of a byte: every
	// rotation is an eight-bit slice of the byte written out twice.
	function automatic logic [CODE_BITS-1:0] smallest_rotation(input logic [CODE_BITS-1:0] b);
		logic [2*CODE_BITS-1:0] twice;
		logic [CODE_BITS-1:0]   best;
		twice = {b, b};
		best  = b;
		for (int k = 1; k < CODE_BITS; k++) begin
			if (twice[k +: CODE_BITS] < best) begin
				best = twice[k +: CODE_BITS];
			end
		end
		return best;
	endfunction

	function automatic void clear_shadow();
		for (int i = 0; i < 2*MAX_WIDTH_DEF; i++) begin
			line_mem[i] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				win[r][c] = '0;
			end
		end
		col_pos      = 0;
		row_pos      = 0;
		frame_width  = WIDTH_RESET;
		frame_height = HEIGHT_RESET;
	endfunction

	// Advance the shadow by one accepted pixel and queue the pattern it
	// yields. The two halves of the line store swap roles each row: the half
	// that held the row two above is overwritten with the incoming one.
	function automatic void predict_pattern(input logic [PIX_IN_BITS-1:0] px);
		int unsigned            old_base;
		int unsigned            mid_base;
		int unsigned            slot;
		logic [PIX_IN_BITS-1:0] top;
		logic [PIX_IN_BITS-1:0] mid;
		logic [PIX_IN_BITS-1:0] centre;
		logic [PIX_IN_BITS-1:0] ring [0:7];
		logic [CODE_BITS-1:0]   cmp;
		result_t                res;
		old_base = (row_pos & 1) * MAX_WIDTH_DEF;
		mid_base = ((row_pos + 1) & 1) * MAX_WIDTH_DEF;
		slot     = col_pos % MAX_WIDTH_DEF;
		top      = line_mem[old_base + slot];
		mid      = line_mem[mid_base + slot];
		line_mem[old_base + slot] = px;

		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = px;

		// interior pixels only: the window is full once two rows and two
		// columns of the frame are in
		if (row_pos >= 2 && col_pos >= 2) begin
			// clockwise from the upper left, first neighbour in the top bit
			ring[0] = win[0][0];
			ring[1] = win[0][1];
			ring[2] = win[0][2];
			ring[3] = win[1][2];
			ring[4] = win[2][2];
			ring[5] = win[2][1];
			ring[6] = win[2][0];
			ring[7] = win[1][0];
			centre  = win[1][1];
			for (int i = 0; i < 8; i++) begin
				cmp[7-i] = (ring[i] >= centre);
			end
			res.code       = smallest_rotation(cmp);
			res.row_last   = (col_pos + 1 == frame_width);
			res.frame_last = res.row_last && (row_pos + 1 == frame_height);
			expected_patterns.push_back(res);
		end

		col_pos++;
		if (col_pos >= frame_width) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= frame_height) begin
				row_pos = 0;
			end
		end
	endfunction

	// Check each pattern transaction against the oldest prediction. Inputs
	// are driven with nonblocking assignments, so values read here are the
	// ones the block saw at this edge.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_patterns.size() == 0) begin
				errors++;
				$display("%0t: unexpected pattern: expected none, %s %02h %s %0b %s %0b",
					$time, "got code", m_tdata, "row_last", m_tlast,
					"frame_last", m_tuser);
			end else begin
				want = expected_patterns.pop_front();
				patterns_checked++;
				if (m_tdata !== want.code || m_tlast !== want.row_last
						|| m_tuser !== want.frame_last) begin
					errors++;
					$display("%0t: pattern mismatch: expected code %02h row_last %0b %s %0b",
						$time, want.code, want.row_last, "frame_last",
						want.frame_last);
					$display("%0t:   got code %02h row_last %0b frame_last %0b",
						$time, m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	// Stall the pattern stream at random, at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Watchdog: count edges with no transaction on any port.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog: no transaction for %0d cycles, %0d patterns outstanding",
				$time, WATCHDOG_LIMIT, expected_patterns.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_gap_pct    = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	// Send one pixel transaction, with random gaps ahead of it. Valid is
	// left high on return so that back-to-back pixels need no second
	// assignment in the same step; whoever comes next lowers it.
	task automatic push_pixel(input logic [PIX_IN_BITS-1:0] px);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		predict_pattern(px);
		pixels_sent++;
	endtask

	// Drop valid, wait until every predicted pattern is out, then let the
	// pipeline run empty.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_patterns.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access until pready. Only ever
	// called with the block idle. Any write restarts the frame.
	task automatic write_reg(input logic idx, input logic [APB_DATA_BITS-1:0] value);
		int unsigned v;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_writes++;
		if (idx == REG_WIDTH) begin
			v = 32'(value[WIDTH_BITS-1:0]);
			frame_width = (v < MIN_DIM) ? MIN_DIM : (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
		end else begin
			v = 32'(value[HEIGHT_BITS-1:0]);
			frame_height = (v < MIN_DIM) ? MIN_DIM : (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v;
		end
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic set_frame(input logic [APB_DATA_BITS-1:0] w, input logic [APB_DATA_BITS-1:0] h);
		wait_drained();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// Flat style keeps neighbours within one grey level of a base so that
	// ties with the centre are frequent; binary style uses only the extremes.
	function automatic logic [PIX_IN_BITS-1:0] random_pixel(input pixel_style_t style,
			input logic [PIX_IN_BITS-1:0] base);
		case (style)
			PIX_FLAT:   return base ^ PIX_IN_BITS'($urandom_range(1));
			PIX_BINARY: return $urandom_range(1) ? '1 : '0;
			default:    return PIX_IN_BITS'($urandom_range(255));
		endcase
	endfunction

	// Stream pixels of one style; now and then hold the source back until
	// every outstanding pattern has come out.
	task automatic send_pixels(input int count, input pixel_style_t style);
		logic [PIX_IN_BITS-1:0] base;
		base = PIX_IN_BITS'($urandom_range(255));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(199) == 0) begin
				wait_drained();
			end
			push_pixel(random_pixel(style, base));
		end
	endtask

	// Reset size of 640 by 480: the first pixels of the top row are border
	// and must give no pattern.
	task automatic test_reset_defaults();
		send_pixels(40, PIX_UNIFORM);
	endtask

	// Smallest frame with every neighbour equal to the centre, then a
	// checkerboard of black and white that gives all-ones and alternating
	// comparison bytes.
	task automatic test_directed_patterns();
		set_frame(3, 3);
		for (int i = 0; i < 9; i++) begin
			push_pixel('1);
		end
		set_frame(5, 3);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 5; c++) begin
				push_pixel(((r + c) & 1) ? '1 : '0);
			end
		end
	endtask

	// Sizes below the minimum, above the maximum, and with bits set above
	// the register width. The widest frame gets only part of its top row.
	task automatic test_range_clamps();
		set_frame(0, 1);
		send_pixels(9, PIX_FLAT);
		set_frame(2, 2);
		send_pixels(9, PIX_UNIFORM);
		set_frame(32'hFFFF_F805, 32'hFFFF_E004);
		send_pixels(20, PIX_BINARY);
		set_frame(MAX_WIDTH_DEF + 1, 0);
		send_pixels(30, PIX_UNIFORM);
	endtask

	// A register write part way through a frame restarts it; line store and
	// window keep what they held.
	task automatic test_restart_midframe();
		set_frame(6, 5);
		send_pixels(17, PIX_UNIFORM);
		wait_drained();
		write_reg(REG_HEIGHT, 5);
		send_pixels(30, PIX_FLAT);
	endtask

	// Narrowest frame with the height clamped to its limit: the first rows
	// must never be flagged as the end of the frame.
	task automatic test_tall_frame();
		set_frame(MIN_DIM, HEIGHT_LIMIT + 1);
		send_pixels(MIN_DIM * 12, PIX_UNIFORM);
	endtask

	// Mostly whole frames of small random size, one or two in a row; one
	// in five is cut short and abandoned by the next register write.
	task automatic test_random_frames(input int target);
		int sent_here;
		int w;
		int h;
		int len;
		sent_here = 0;
		while (sent_here < target) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 10);
			h = $urandom_range(3, 7);
			set_frame(w, h);
			len = w * h * $urandom_range(1, 2);
			if ($urandom_range(4) == 0) begin
				len = $urandom_range(1, w * h - 1);
			end
			send_pixels(len, pixel_style_t'($urandom_range(2)));
			sent_here += len;
		end
	endtask

	initial begin
		clear_shadow();
		set_idling(8, 49);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// light source gaps, heavy sink stalls
		test_reset_defaults();
		test_directed_patterns();
		test_random_frames(RANDOM_CHUNK);

		// heavy source gaps, light sink stalls
		set_idling(49, 8);
		test_range_clamps();
		test_restart_midframe();
		test_random_frames(RANDOM_CHUNK);

		// full rate both ways
		set_idling(0, 0);
		test_tall_frame();
		test_random_frames(RANDOM_CHUNK);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d pixels and %0d patterns over %0d register writes",
			pixels_sent, patterns_checked, reg_writes);
		$display("small random frames, reset size, clamped sizes, restart mid-frame, stalls");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
rtl/rilbp_pkg.sv
rtl/rilbp_ram.sv
rtl/rotation_invariant_lbp.sv
tb/sv/rotation_invariant_lbp_tb.sv
